// File: hw/rtl/stw_pkg.sv
// shared types and constants for the starved thread watch block
// no dependencies; used by stw_cfg_regs, stw_core and the top level
package stw_pkg;

  localparam int unsigned IdW    = 8;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned SecW   = 16;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned ActW   = 3;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // result action codes
  localparam logic [ActW-1:0] ACT_NONE   = 3'd0;
  localparam logic [ActW-1:0] ACT_RESET  = 3'd1;
  localparam logic [ActW-1:0] ACT_KILL   = 3'd2;
  localparam logic [ActW-1:0] ACT_SAVE   = 3'd3;
  localparam logic [ActW-1:0] ACT_RESUME = 3'd4;

  // resolve modes
  localparam logic [ModeW-1:0] MODE_KILL        = 2'd1;
  localparam logic [ModeW-1:0] MODE_KILL_RESUME = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_IDLE_PRIO   = 3'd0;
  localparam logic [2:0] REG_WAIT_SEC    = 3'd1;
  localparam logic [2:0] REG_CONFIRM_SEC = 3'd2;
  localparam logic [2:0] REG_RESUME_SEC  = 3'd3;
  localparam logic [2:0] REG_MODE        = 3'd4;
  localparam logic [2:0] REG_WATCHER_ID  = 3'd5;

  // reset values
  localparam logic [PrioW-1:0] IDLE_PRIO_RST   = 8'd31;
  localparam logic [SecW-1:0]  WAIT_SEC_RST    = 16'd10;
  localparam logic [SecW-1:0]  CONFIRM_SEC_RST = 16'd2;
  localparam logic [SecW-1:0]  RESUME_SEC_RST  = 16'd10;

  typedef struct packed {
    logic [PrioW-1:0] idle_priority;
    logic [SecW-1:0]  wait_seconds;
    logic [SecW-1:0]  confirm_seconds;
    logic [SecW-1:0]  resume_delay_seconds;
    logic [ModeW-1:0] resolve_mode;
    logic [IdW-1:0]   watcher_thread_id;
  } cfg_t;

endpackage

// File: hw/rtl/starved_thread_watch_fsm_unit.sv
// starved thread watch: top level with apb registers and the watch core
// an accepted beat passes the input register, then the result register
// throughput: one beat per cycle while the result register is not stalled
// in_ready drops only while the input register holds a beat and the result register is stalled
// reset: synchronous active-low rst_n; registers return to defaults, state to waiting
// depends on stw_pkg, stw_cfg_regs, stw_core
module starved_thread_watch_fsm_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [stw_pkg::AddrW-1:0]  paddr,
  input  logic [stw_pkg::DataW-1:0]  pwdata,
  output logic [stw_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_func,
  input  logic [stw_pkg::IdW-1:0]    in_from_thread,
  input  logic [stw_pkg::PrioW-1:0]  in_from_priority,
  input  logic                       in_from_running,
  input  logic [stw_pkg::IdW-1:0]    in_to_thread,
  input  logic [stw_pkg::PrioW-1:0]  in_to_priority,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [stw_pkg::ActW-1:0]   out_action,
  output logic [stw_pkg::IdW-1:0]    out_target_thread,
  output logic                       out_feed_watchdog
);

  stw_pkg::cfg_t cfg;

  stw_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stw_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_from_thread    (in_from_thread),
    .in_from_priority  (in_from_priority),
    .in_from_running   (in_from_running),
    .in_to_thread      (in_to_thread),
    .in_to_priority    (in_to_priority),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_action        (out_action),
    .out_target_thread (out_target_thread),
    .out_feed_watchdog (out_feed_watchdog)
  );

  // switch beats never carry an action
  a_switch_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_feed_watchdog |-> out_action == stw_pkg::ACT_NONE)
    else $error("switch beat produced an action");

  // only thread actions name a thread
  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == stw_pkg::ACT_NONE || out_action == stw_pkg::ACT_RESUME)
      |-> out_target_thread == '0)
    else $error("target set without a thread action");

  // a stalled result must not be overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) && $stable(out_target_thread))
    else $error("stalled result changed");

  // no action code beyond resume
  a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_action <= stw_pkg::ACT_RESUME)
    else $error("invalid action code");

endmodule

// File: hw/rtl/stw_cfg_regs.sv
// apb configuration registers of the starved thread watch block
// depends on stw_pkg
module stw_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [stw_pkg::AddrW-1:0]  paddr,
  input  logic [stw_pkg::DataW-1:0]  pwdata,
  output logic [stw_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output stw_pkg::cfg_t              cfg
);

  stw_pkg::cfg_t cfg_r;
  stw_pkg::cfg_t cfg_nxt;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        stw_pkg::REG_IDLE_PRIO:   cfg_nxt.idle_priority        = pwdata[stw_pkg::PrioW-1:0];
        stw_pkg::REG_WAIT_SEC:    cfg_nxt.wait_seconds         = pwdata[stw_pkg::SecW-1:0];
        stw_pkg::REG_CONFIRM_SEC: cfg_nxt.confirm_seconds      = pwdata[stw_pkg::SecW-1:0];
        stw_pkg::REG_RESUME_SEC:  cfg_nxt.resume_delay_seconds = pwdata[stw_pkg::SecW-1:0];
        stw_pkg::REG_MODE:        cfg_nxt.resolve_mode         = pwdata[stw_pkg::ModeW-1:0];
        stw_pkg::REG_WATCHER_ID:  cfg_nxt.watcher_thread_id    = pwdata[stw_pkg::IdW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_priority        <= stw_pkg::IDLE_PRIO_RST;
      cfg_r.wait_seconds         <= stw_pkg::WAIT_SEC_RST;
      cfg_r.confirm_seconds      <= stw_pkg::CONFIRM_SEC_RST;
      cfg_r.resume_delay_seconds <= stw_pkg::RESUME_SEC_RST;
      cfg_r.resolve_mode         <= '0;
      cfg_r.watcher_thread_id    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      stw_pkg::REG_IDLE_PRIO:   prdata[stw_pkg::PrioW-1:0] = cfg_r.idle_priority;
      stw_pkg::REG_WAIT_SEC:    prdata[stw_pkg::SecW-1:0]  = cfg_r.wait_seconds;
      stw_pkg::REG_CONFIRM_SEC: prdata[stw_pkg::SecW-1:0]  = cfg_r.confirm_seconds;
      stw_pkg::REG_RESUME_SEC:  prdata[stw_pkg::SecW-1:0]  = cfg_r.resume_delay_seconds;
      stw_pkg::REG_MODE:        prdata[stw_pkg::ModeW-1:0] = cfg_r.resolve_mode;
      stw_pkg::REG_WATCHER_ID:  prdata[stw_pkg::IdW-1:0]   = cfg_r.watcher_thread_id;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/stw_core.sv
// input register, watch state machine and result register
// depends on stw_pkg
module stw_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  stw_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_func,
  input  logic [stw_pkg::IdW-1:0]    in_from_thread,
  input  logic [stw_pkg::PrioW-1:0]  in_from_priority,
  input  logic                       in_from_running,
  input  logic [stw_pkg::IdW-1:0]    in_to_thread,
  input  logic [stw_pkg::PrioW-1:0]  in_to_priority,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [stw_pkg::ActW-1:0]   out_action,
  output logic [stw_pkg::IdW-1:0]    out_target_thread,
  output logic                       out_feed_watchdog
);

  typedef enum logic [1:0] {
    PH_WAITING    = 2'd0,
    PH_CONFIRMING = 2'd1,
    PH_RESUMING   = 2'd2
  } phase_t;

  // input register
  logic                      s1_vld_r;
  logic                      func_r;
  logic [stw_pkg::IdW-1:0]   fid_r;
  logic [stw_pkg::PrioW-1:0] fpr_r;
  logic                      frun_r;
  logic [stw_pkg::IdW-1:0]   tid_r;
  logic [stw_pkg::PrioW-1:0] tpr_r;

  // watch state
  phase_t                    phase_r, phase_nxt;
  logic [stw_pkg::SecW-1:0]  cnt_r, cnt_nxt;
  logic                      tv_r, tv_nxt;
  logic [stw_pkg::IdW-1:0]   tt_r, tt_nxt;
  logic [stw_pkg::PrioW-1:0] tp_r, tp_nxt;
  logic                      pend_r, pend_nxt;

  // result register
  logic                      out_vld_r;
  logic [stw_pkg::ActW-1:0]  act_r, act_nxt;
  logic [stw_pkg::IdW-1:0]   tgt_r, tgt_nxt;
  logic                      feed_r;

  logic                      s1_adv;
  logic                      in_acc;
  logic [stw_pkg::SecW-1:0]  cnt_inc;

  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign cnt_inc  = cnt_r + 16'd1;

  assign out_valid         = out_vld_r;
  assign out_action        = act_r;
  assign out_target_thread = tgt_r;
  assign out_feed_watchdog = feed_r;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    tv_nxt    = tv_r;
    tt_nxt    = tt_r;
    tp_nxt    = tp_r;
    pend_nxt  = pend_r;
    act_nxt   = stw_pkg::ACT_NONE;
    tgt_nxt   = '0;
    if (func_r) begin
      // switch to a numerically lower priority is ignored
      if (fpr_r <= tpr_r) begin
        if (tpr_r == cfg.idle_priority) begin
          if (cfg.resolve_mode == stw_pkg::MODE_KILL_RESUME) begin
            if (phase_r == PH_WAITING) begin
              cnt_nxt = '0;
            end else if (phase_r == PH_CONFIRMING) begin
              cnt_nxt   = '0;
              phase_nxt = pend_r ? PH_RESUMING : PH_WAITING;
            end
          end else begin
            cnt_nxt   = '0;
            phase_nxt = PH_WAITING;
          end
        end else if (phase_r == PH_CONFIRMING) begin
          if (!tv_r || tpr_r > tp_r) begin
            tv_nxt = 1'b1;
            tt_nxt = tid_r;
            tp_nxt = tpr_r;
          end else if (tpr_r == tp_r && tpr_r == fpr_r && frun_r) begin
            // same-priority yield moves the record to the yielding thread
            tv_nxt = 1'b1;
            tt_nxt = fid_r;
            tp_nxt = fpr_r;
          end
        end
      end
    end else begin
      case (phase_r)
        PH_WAITING: begin
          if (cnt_inc < cfg.wait_seconds) begin
            cnt_nxt = cnt_inc;
          end else begin
            cnt_nxt   = '0;
            phase_nxt = PH_CONFIRMING;
            tv_nxt    = 1'b0;
          end
        end
        PH_CONFIRMING: begin
          if (cnt_inc < cfg.confirm_seconds) begin
            cnt_nxt = cnt_inc;
          end else begin
            cnt_nxt = '0;
            tv_nxt  = 1'b0;
            if (tv_r && tt_r != cfg.watcher_thread_id) begin
              tgt_nxt = tt_r;
              if (cfg.resolve_mode == stw_pkg::MODE_KILL) begin
                act_nxt = stw_pkg::ACT_KILL;
              end else if (cfg.resolve_mode == stw_pkg::MODE_KILL_RESUME) begin
                act_nxt  = stw_pkg::ACT_SAVE;
                pend_nxt = 1'b1;
              end else begin
                act_nxt = stw_pkg::ACT_RESET;
              end
            end
          end
        end
        PH_RESUMING: begin
          if (cfg.resolve_mode != stw_pkg::MODE_KILL_RESUME) begin
            phase_nxt = PH_WAITING;
            cnt_nxt   = '0;
          end else if (cnt_inc < cfg.resume_delay_seconds) begin
            cnt_nxt = cnt_inc;
          end else begin
            cnt_nxt   = '0;
            act_nxt   = stw_pkg::ACT_RESUME;
            pend_nxt  = 1'b0;
            phase_nxt = PH_WAITING;
          end
        end
        default: begin
          phase_nxt = PH_WAITING;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= PH_WAITING;
      cnt_r     <= '0;
      tv_r      <= 1'b0;
      tt_r      <= '0;
      tp_r      <= '0;
      pend_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
        phase_r   <= phase_nxt;
        cnt_r     <= cnt_nxt;
        tv_r      <= tv_nxt;
        tt_r      <= tt_nxt;
        tp_r      <= tp_nxt;
        pend_r    <= pend_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      fid_r  <= in_from_thread;
      fpr_r  <= in_from_priority;
      frun_r <= in_from_running;
      tid_r  <= in_to_thread;
      tpr_r  <= in_to_priority;
    end
    if (s1_adv) begin
      act_r  <= act_nxt;
      tgt_r  <= tgt_nxt;
      feed_r <= !func_r;
    end
  end

endmodule

// File: bench/tb_starved_thread_watch_fsm_unit.sv
// testbench for starved_thread_watch_fsm_unit: directed table, then random phases
// predicts results from its own model of the watch state, except rows given a fixed verdict; needs stw_pkg and the rtl
`timescale 1ns / 100ps

module tb_starved_thread_watch_fsm_unit;

  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;
  localparam int unsigned NUM_PHASES   = 12;
  localparam int unsigned PHASE_BEATS  = 112;
  localparam int unsigned HOLD_CYCLES  = 300;

  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_SWITCH = 1'b1;
  localparam logic [stw_pkg::ModeW-1:0] MODE_RESET = 2'd0;
  localparam logic [stw_pkg::ModeW-1:0] MODE_SPARE = 2'd3;

  typedef enum logic [1:0] {PH_WAIT, PH_CONFIRM, PH_RESUME, PH_STRAY} watch_phase_t;
  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic                      func;
    logic [stw_pkg::IdW-1:0]   from_thread;
    logic [stw_pkg::PrioW-1:0] from_prio;
    logic                      from_run;
    logic [stw_pkg::IdW-1:0]   to_thread;
    logic [stw_pkg::PrioW-1:0] to_prio;
  } sched_evt_t;

  typedef struct packed {
    logic [stw_pkg::ActW-1:0] action;
    logic [stw_pkg::IdW-1:0]  target;
    logic                     feed;
  } verdict_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    sched_evt_t  evt;
    bit          typed;
    verdict_t    typed_v;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [stw_pkg::AddrW-1:0] paddr;
  logic [stw_pkg::DataW-1:0] pwdata, prdata;
  logic in_valid, in_ready;
  logic in_func, in_from_running;
  logic [stw_pkg::IdW-1:0] in_from_thread, in_to_thread;
  logic [stw_pkg::PrioW-1:0] in_from_priority, in_to_priority;
  logic out_valid, out_ready;
  logic [stw_pkg::ActW-1:0] out_action;
  logic [stw_pkg::IdW-1:0] out_target_thread;
  logic out_feed_watchdog;

  // predictor copy of registers and watch state
  stw_pkg::cfg_t             shadow_cfg;
  watch_phase_t              watch_phase;
  logic [stw_pkg::SecW-1:0]  second_cnt;
  logic                      trk_valid;
  logic [stw_pkg::IdW-1:0]   trk_thread;
  logic [stw_pkg::PrioW-1:0] trk_prio;
  logic                      resume_owed;

  verdict_t    expected_verdicts[$];
  stim_row_t   stim_rows[$];
  int unsigned n_errors;
  int unsigned beats_sent;
  int unsigned settings_used;
  int unsigned action_count[0:4];

  // stimulus shaping
  bit          sender_gaps;
  int unsigned burst_left;
  bit          hold_req;
  int unsigned tick_pct, idle_pct;
  logic [stw_pkg::PrioW-1:0] prio_base;

  starved_thread_watch_fsm_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_from_thread    (in_from_thread),
    .in_from_priority  (in_from_priority),
    .in_from_running   (in_from_running),
    .in_to_thread      (in_to_thread),
    .in_to_priority    (in_to_priority),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_action        (out_action),
    .out_target_thread (out_target_thread),
    .out_feed_watchdog (out_feed_watchdog)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // second counter step; true when the limit is hit, counter wraps at 16 bits
  function automatic bit seconds_expired(input logic [stw_pkg::SecW-1:0] limit);
    second_cnt = second_cnt + 16'd1;
    if (second_cnt < limit) return 1'b0;
    second_cnt = '0;
    return 1'b1;
  endfunction

  task automatic predict_watch(input sched_evt_t ev, output verdict_t v);
    v = '0;
    if (ev.func == FUNC_SWITCH) begin
      // switches whose outgoing side has the higher priority number are dropped
      if (ev.from_prio <= ev.to_prio) begin
        if (ev.to_prio == shadow_cfg.idle_priority) begin
          if (shadow_cfg.resolve_mode == stw_pkg::MODE_KILL_RESUME) begin
            if (watch_phase == PH_WAIT) begin
              second_cnt = '0;
            end else if (watch_phase == PH_CONFIRM) begin
              second_cnt  = '0;
              watch_phase = resume_owed ? PH_RESUME : PH_WAIT;
            end
          end else begin
            second_cnt  = '0;
            watch_phase = PH_WAIT;
          end
        end else if (watch_phase == PH_CONFIRM) begin
          if (!trk_valid || ev.to_prio > trk_prio) begin
            trk_valid  = 1'b1;
            trk_thread = ev.to_thread;
            trk_prio   = ev.to_prio;
          end else if (ev.to_prio == trk_prio && ev.to_prio == ev.from_prio && ev.from_run) begin
            // same-priority yield moves the tracking to the yielding thread
            trk_valid  = 1'b1;
            trk_thread = ev.from_thread;
            trk_prio   = ev.from_prio;
          end
        end
      end
    end else begin
      v.feed = 1'b1;
      case (watch_phase)
        PH_WAIT: begin
          if (seconds_expired(shadow_cfg.wait_seconds)) begin
            watch_phase = PH_CONFIRM;
            trk_valid   = 1'b0;
          end
        end
        PH_CONFIRM: begin
          if (seconds_expired(shadow_cfg.confirm_seconds)) begin
            if (trk_valid && trk_thread != shadow_cfg.watcher_thread_id) begin
              v.target = trk_thread;
              if (shadow_cfg.resolve_mode == stw_pkg::MODE_KILL) begin
                v.action = stw_pkg::ACT_KILL;
              end else if (shadow_cfg.resolve_mode == stw_pkg::MODE_KILL_RESUME) begin
                v.action    = stw_pkg::ACT_SAVE;
                resume_owed = 1'b1;
              end else begin
                v.action = stw_pkg::ACT_RESET;
              end
            end
            trk_valid = 1'b0;
          end
        end
        default: begin
          if (watch_phase == PH_RESUME &&
              shadow_cfg.resolve_mode == stw_pkg::MODE_KILL_RESUME) begin
            if (seconds_expired(shadow_cfg.resume_delay_seconds)) begin
              v.action    = stw_pkg::ACT_RESUME;
              resume_owed = 1'b0;
              watch_phase = PH_WAIT;
            end
          end else begin
            watch_phase = PH_WAIT;
            second_cnt  = '0;
          end
        end
      endcase
    end
  endtask

  function automatic sched_evt_t switch_evt(input logic [7:0] fid, input logic [7:0] fpr,
                                            input logic frun, input logic [7:0] tid,
                                            input logic [7:0] tpr);
    return '{func: FUNC_SWITCH, from_thread: fid, from_prio: fpr, from_run: frun,
             to_thread: tid, to_prio: tpr};
  endfunction

  function automatic void add_beat(input sched_evt_t e, input bit typed = 1'b0,
                                   input verdict_t v = '0);
    stim_row_t r;
    r.kind    = ROW_BEAT;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.evt     = e;
    r.typed   = typed;
    r.typed_v = v;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [2:0] idx, input logic [31:0] value);
    stim_row_t r;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = value;
    r.evt     = '0;
    r.typed   = 1'b0;
    r.typed_v = '0;
    stim_rows.push_back(r);
  endfunction

  function automatic sched_evt_t random_evt();
    sched_evt_t e;
    logic [63:0] raw;
    int unsigned r;
    raw = {$urandom, $urandom};
    e = raw[$bits(sched_evt_t)-1:0];
    r = $urandom_range(0, 99);
    if (r < tick_pct) begin
      e.func = FUNC_TICK;  // payload left random, the block ignores it
    end else begin
      e.func = FUNC_SWITCH;
      r = $urandom_range(0, 99);
      if (r < idle_pct) e.to_prio = shadow_cfg.idle_priority;
      else if (r < 65) e.to_prio = prio_base + 8'($urandom_range(0, 7));
      r = $urandom_range(0, 99);
      if (r < 25) e.from_prio = e.to_prio;
      else if (r < 85) e.from_prio = 8'($urandom_range(0, e.to_prio));
      if ($urandom_range(0, 6) == 0) e.to_thread = shadow_cfg.watcher_thread_id;
    end
    return e;
  endfunction

  task automatic push_beat(input sched_evt_t ev, input bit typed, input verdict_t typed_v);
    verdict_t v;
    int unsigned gap;
    @(negedge clk);
    in_valid         <= 1'b1;
    in_func          <= ev.func;
    in_from_thread   <= ev.from_thread;
    in_from_priority <= ev.from_prio;
    in_from_running  <= ev.from_run;
    in_to_thread     <= ev.to_thread;
    in_to_priority   <= ev.to_prio;
    do @(posedge clk); while (!in_ready);
    predict_watch(ev, v);
    expected_verdicts.push_back(typed ? typed_v : v);
    beats_sent++;
    gap = 0;
    if (burst_left != 0) begin
      burst_left--;
    end else if (sender_gaps) begin
      gap        = $urandom_range(1, 5);
      burst_left = $urandom_range(0, 16);
    end
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // writes only once the block has drained, then reads the value back
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] masked;
    masked = '0;
    case (idx)
      stw_pkg::REG_IDLE_PRIO: begin
        masked[stw_pkg::PrioW-1:0] = value[stw_pkg::PrioW-1:0];
        shadow_cfg.idle_priority = value[stw_pkg::PrioW-1:0];
      end
      stw_pkg::REG_WAIT_SEC: begin
        masked[stw_pkg::SecW-1:0] = value[stw_pkg::SecW-1:0];
        shadow_cfg.wait_seconds = value[stw_pkg::SecW-1:0];
      end
      stw_pkg::REG_CONFIRM_SEC: begin
        masked[stw_pkg::SecW-1:0] = value[stw_pkg::SecW-1:0];
        shadow_cfg.confirm_seconds = value[stw_pkg::SecW-1:0];
      end
      stw_pkg::REG_RESUME_SEC: begin
        masked[stw_pkg::SecW-1:0] = value[stw_pkg::SecW-1:0];
        shadow_cfg.resume_delay_seconds = value[stw_pkg::SecW-1:0];
      end
      stw_pkg::REG_MODE: begin
        masked[stw_pkg::ModeW-1:0] = value[stw_pkg::ModeW-1:0];
        shadow_cfg.resolve_mode = value[stw_pkg::ModeW-1:0];
      end
      stw_pkg::REG_WATCHER_ID: begin
        masked[stw_pkg::IdW-1:0] = value[stw_pkg::IdW-1:0];
        shadow_cfg.watcher_thread_id = value[stw_pkg::IdW-1:0];
      end
      default: ;
    endcase
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= masked;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== masked) begin
      $display("%0t: register %0d readback: expected %h, got %h", $time, idx, masked, prdata);
      n_errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: stall pattern of its own, plus one long hold when asked
  initial begin : result_sink
    int unsigned cyc;
    int unsigned hold_left;
    bit          hold_taken;
    logic [15:0] pat;
    cyc        = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    pat        = 16'hFFFF;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        if (cyc % 48 == 0) pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
        out_ready <= pat[cyc % 16];
        cyc++;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (out_action <= stw_pkg::ACT_RESUME) action_count[out_action]++;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result beat with nothing expected: action %0d target %0d feed %0d",
                 $time, out_action, out_target_thread, out_feed_watchdog);
        n_errors++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_action !== want.action || out_target_thread !== want.target ||
            out_feed_watchdog !== want.feed) begin
          $display("%0t: mismatch: expected action %0d target %0d feed %0d, got %0d %0d %0d",
                   $time, want.action, want.target, want.feed,
                   out_action, out_target_thread, out_feed_watchdog);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    sched_evt_t tick;
    sched_evt_t idle_sw;
    verdict_t   quiet_tick;
    verdict_t   quiet_switch;
    tick         = '{func: FUNC_TICK, default: '0};
    idle_sw      = switch_evt(8'd5, 8'd0, 1'b0, 8'd6, stw_pkg::IDLE_PRIO_RST);
    quiet_tick   = '{action: stw_pkg::ACT_NONE, target: '0, feed: 1'b1};
    quiet_switch = '{action: stw_pkg::ACT_NONE, target: '0, feed: 1'b0};

    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_valid         = 1'b0;
    in_func          = 1'b0;
    in_from_thread   = '0;
    in_from_priority = '0;
    in_from_running  = 1'b0;
    in_to_thread     = '0;
    in_to_priority   = '0;
    hold_req         = 1'b0;
    sender_gaps      = 1'b1;
    burst_left       = 0;
    n_errors         = 0;
    beats_sent       = 0;
    settings_used    = 1;
    foreach (action_count[i]) action_count[i] = 0;

    shadow_cfg.idle_priority        = stw_pkg::IDLE_PRIO_RST;
    shadow_cfg.wait_seconds         = stw_pkg::WAIT_SEC_RST;
    shadow_cfg.confirm_seconds      = stw_pkg::CONFIRM_SEC_RST;
    shadow_cfg.resume_delay_seconds = stw_pkg::RESUME_SEC_RST;
    shadow_cfg.resolve_mode         = MODE_RESET;
    shadow_cfg.watcher_thread_id    = '0;
    watch_phase = PH_WAIT;
    second_cnt  = '0;
    trk_valid   = 1'b0;
    trk_thread  = '0;
    trk_prio    = '0;
    resume_owed = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, starting from the reset register values
    add_beat(tick, 1'b1, quiet_tick);
    add_beat(switch_evt(8'hFF, 8'hFF, 1'b1, 8'hFF, 8'h00), 1'b1, quiet_switch);
    add_cfg(stw_pkg::REG_WAIT_SEC, 32'd0);
    add_beat(tick, 1'b1, quiet_tick);                        // zero wait: into confirming
    add_beat(switch_evt(8'd3, 8'd5, 1'b0, 8'd7, 8'd10));
    add_beat(switch_evt(8'd4, 8'd5, 1'b0, 8'd8, 8'd9));      // higher priority, not tracked
    add_beat(switch_evt(8'd9, 8'd10, 1'b1, 8'd11, 8'd10));   // same-priority yield
    add_beat(tick);
    add_beat(tick);                                          // system reset of the yielder
    add_beat(tick);
    add_beat(tick);                                          // nothing tracked
    add_cfg(stw_pkg::REG_WATCHER_ID, 32'h2A);
    add_cfg(stw_pkg::REG_MODE, 32'(stw_pkg::MODE_KILL));
    add_beat(switch_evt(8'd0, 8'd0, 1'b0, 8'h2A, 8'd200));
    add_beat(tick);
    add_beat(tick);                                          // watcher is never reported
    add_beat(switch_evt(8'd1, 8'd2, 1'b0, 8'd20, 8'd50));
    add_beat(tick);
    add_beat(tick);
    add_cfg(stw_pkg::REG_MODE, 32'(stw_pkg::MODE_KILL_RESUME));
    add_cfg(stw_pkg::REG_CONFIRM_SEC, 32'd0);
    add_beat(switch_evt(8'd1, 8'd2, 1'b0, 8'd21, 8'd60));
    add_beat(tick);                                          // save and kill
    add_beat(idle_sw);                                       // kills pending: go resuming
    add_beat(idle_sw);                                       // idle while resuming is ignored
    add_cfg(stw_pkg::REG_RESUME_SEC, 32'd0);
    add_beat(tick);                                          // resume all
    add_beat(tick);
    add_beat(switch_evt(8'hFF, 8'hFE, 1'b1, 8'hFF, 8'hFE));
    add_beat(tick);
    add_beat(idle_sw);
    add_cfg(stw_pkg::REG_MODE, 32'(MODE_SPARE));
    add_beat(tick);                                          // resuming outside mode 2
    add_beat(idle_sw);
    add_beat(tick);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
      else push_beat(stim_rows[i].evt, stim_rows[i].typed, stim_rows[i].typed_v);
    end

    // random phases, each with its own register setting and traffic shape
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      write_reg(stw_pkg::REG_IDLE_PRIO,
                (p == 0) ? 32'd0 : (p == 1) ? 32'd255 : $urandom_range(0, 255));
      write_reg(stw_pkg::REG_WAIT_SEC, (p == 2) ? 32'hFFFF : $urandom_range(0, 5));
      write_reg(stw_pkg::REG_CONFIRM_SEC, (p == 5) ? 32'hFFFF : $urandom_range(0, 4));
      write_reg(stw_pkg::REG_RESUME_SEC, (p == 6) ? 32'hFFFF : $urandom_range(0, 5));
      write_reg(stw_pkg::REG_MODE,
                (p % 3 == 0) ? 32'(stw_pkg::MODE_KILL_RESUME) : $urandom_range(0, 3));
      write_reg(stw_pkg::REG_WATCHER_ID,
                (p == 3) ? 32'd255 : (p == 4) ? 32'd0 : $urandom_range(0, 255));
      settings_used++;
      tick_pct    = $urandom_range(25, 45);
      idle_pct    = (p % 3 == 0) ? 2 : (p % 3 == 1) ? 10 : 25;
      prio_base   = 8'($urandom_range(0, 255));
      sender_gaps = (p % 4 != 1) && (p != 7);
      burst_left  = 0;
      // one phase runs the sender flat out against a long receiver hold
      if (p == 7) hold_req = 1'b1;
      for (int unsigned n = 0; n < PHASE_BEATS; n++) push_beat(random_evt(), 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d beats over %0d register settings", beats_sent, settings_used);
    $display("results: %0d quiet, %0d resets, %0d kills, %0d save-kills, %0d resumes",
             action_count[stw_pkg::ACT_NONE], action_count[stw_pkg::ACT_RESET],
             action_count[stw_pkg::ACT_KILL], action_count[stw_pkg::ACT_SAVE],
             action_count[stw_pkg::ACT_RESUME]);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
